FILE: rtl/mcutp_pkg.sv
// mcutp_pkg: shared types and constants for the page-zero timer and port block
// holds the item layout, operation codes, register map and timer control bits
// no dependencies
`default_nettype none

package mcutp_pkg;

   // block configuration defaults
   localparam int RAM_BYTES_DEFAULT = 112;

   // item operations
   typedef enum logic [1:0] {
      OP_READ  = 2'd0,
      OP_WRITE = 2'd1,
      OP_TICK  = 2'd2,
      OP_PINS  = 2'd3
   } op_type;

   // one accepted request beat
   typedef struct packed {
      op_type     operation;
      logic [6:0] address;
      logic [7:0] write_data;
      logic [7:0] elapsed_cycles;
      logic [1:0] port_select;
   } item_type;

   // controller to datapath commands
   typedef struct packed {
      logic capture;   // latch the incoming item, start the ram read
      logic commit;    // apply the held item and load the read data register
   } cmd_type;

   // configuration register indexes
   localparam logic CSR_PRESCALE = 1'b0;
   localparam logic CSR_EXT_CLK  = 1'b1;

   // page-zero register map
   localparam logic [6:0] ADDR_PORT_A   = 7'h00;
   localparam logic [6:0] ADDR_PORT_B   = 7'h01;
   localparam logic [6:0] ADDR_PORT_C   = 7'h02;
   localparam logic [6:0] ADDR_DDR_A    = 7'h04;
   localparam logic [6:0] ADDR_DDR_B    = 7'h05;
   localparam logic [6:0] ADDR_DDR_C    = 7'h06;
   localparam logic [6:0] ADDR_TDR      = 7'h08;
   localparam logic [6:0] ADDR_TCR      = 7'h09;
   localparam logic [6:0] ADDR_PCR      = 7'h0B;

   // port selectors of a pin update
   localparam logic [1:0] PORT_SEL_A = 2'd0;
   localparam logic [1:0] PORT_SEL_B = 2'd1;
   localparam logic [1:0] PORT_SEL_C = 2'd2;

   // port c upper bits are not bonded out and read as one
   localparam logic [7:0] PORT_C_FIXED = 8'hF0;

   // timer control bits
   localparam logic [7:0] TCR_TIR = 8'h80;
   localparam logic [7:0] TCR_TIM = 8'h40;
   localparam logic [7:0] TCR_TIE = 8'h10;
   localparam logic [7:0] TCR_PSC = 8'h08;

   // reset values
   localparam logic [7:0] LATCH_RESET = 8'hFF;
   localparam logic [7:0] DDR_RESET   = 8'h00;
   localparam logic [7:0] PIN_RESET   = 8'hFF;
   localparam logic [7:0] PCR_RESET   = 8'hFF;
   localparam logic [6:0] PRESC_RESET = 7'h7F;
   localparam logic [7:0] TDR_RESET   = 8'hFF;
   localparam logic [7:0] TCR_RESET   = 8'h7F;
   localparam logic [2:0] SHIFT_RESET = 3'd7;

   // program control: only the low two bits are writable
   localparam logic [7:0] PCR_KEEP = 8'hFC;
   localparam logic [7:0] PCR_WMASK = 8'h03;

   // read value of holes and write-only registers
   localparam logic [7:0] OPEN_BUS = 8'hFF;

endpackage

`default_nettype wire

FILE: rtl/mcutp_ram.sv
// mcutp_ram: generic single-write, single-read ram with registered read data
// no package dependencies
`default_nettype none

module mcutp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 112
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

FILE: rtl/mcutp_ctrl.sv
// mcutp_ctrl: item sequencer and response valid for the timer and port block
// depends on mcutp_pkg for the command struct
`default_nettype none

module mcutp_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output      logic              req_tready,
   output      logic              rsp_tvalid,
   input  wire logic              rsp_tready,
   output      mcutp_pkg::cmd_type cmd
);
   import mcutp_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   // the output register is free when empty or being drained this cycle
   assign slot_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready  = (state_ff == ST_IDLE);
   assign rsp_tvalid  = rsp_valid_ff;
   assign cmd.capture = req_tvalid && (state_ff == ST_IDLE);
   assign cmd.commit  = (state_ff == ST_EXEC) && slot_free;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.capture) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (cmd.commit) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // response valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // a committed item always shows up as a response beat
   a_commit_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_tvalid)
      else $error("commit did not raise response valid");

   // a captured item is held for execution
   a_capture_to_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> (state_ff == ST_EXEC))
      else $error("captured item not in execution");

   // an item waits while the output register is full
   a_exec_holds: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_EXEC) && !cmd.commit) |=> (state_ff == ST_EXEC))
      else $error("item dropped while response stalled");

endmodule

`default_nettype wire

FILE: rtl/mcutp_datapath.sv
// mcutp_datapath: port, timer, program control registers and scratch ram
// depends on mcutp_pkg and mcutp_ram
`default_nettype none

module mcutp_datapath #(
   parameter int RAM_BYTES = mcutp_pkg::RAM_BYTES_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire mcutp_pkg::cmd_type  cmd,
   input  wire mcutp_pkg::item_type req_item,
   input  wire logic                csr_write,
   input  wire logic                csr_index,
   input  wire logic [7:0]          csr_data,
   output      logic [7:0]          read_data,
   output      logic                timer_irq,
   output      logic [7:0]          port_a_pins,
   output      logic [7:0]          port_b_pins,
   output      logic [7:0]          port_c_pins
);
   import mcutp_pkg::*;

   localparam int         RAM_AW   = $clog2(RAM_BYTES);
   localparam logic [6:0] RAM_BASE = 7'(128 - RAM_BYTES);

   item_type    item_ff;
   logic [7:0]  rd_data_ff, rd_data_in;
   logic [7:0]  latch_ff [3];
   logic [7:0]  latch_in [3];
   logic [7:0]  ddr_ff [3];
   logic [7:0]  ddr_in [3];
   logic [7:0]  pin_ff [3];
   logic [7:0]  pin_in [3];
   logic [7:0]  pcr_ff, pcr_in;
   logic [6:0]  presc_ff, presc_in;
   logic [7:0]  tdr_ff, tdr_in;
   logic [7:0]  tcr_ff, tcr_in;
   logic        irq_ff, irq_in;
   logic [2:0]  shift_ff;
   logic        ext_clk_ff;

   logic              ram_hit;
   logic              ram_wr_en;
   logic [RAM_AW-1:0] ram_wr_addr;
   logic [RAM_AW-1:0] ram_rd_addr;
   logic [7:0]        ram_rd_data;

   logic [6:0]  presc_mask;
   logic [8:0]  presc_sum;
   logic [8:0]  tick_dec;
   logic [8:0]  tdr_span;
   logic        tick_fire;
   logic [7:0]  tcr_wr;
   logic [7:0]  tcr_after_wr;
   logic [7:0]  pcr_wr;

   // scratch ram, read at capture so data is ready while the item executes
   assign ram_hit     = (item_ff.address >= RAM_BASE);
   assign ram_wr_addr = RAM_AW'(item_ff.address - RAM_BASE);
   assign ram_rd_addr = RAM_AW'(req_item.address - RAM_BASE);
   assign ram_wr_en   = cmd.commit && (item_ff.operation == OP_WRITE) && ram_hit;

   mcutp_ram #(
      .WIDTH (8),
      .DEPTH (RAM_BYTES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (item_ff.write_data),
      .rd_en   (cmd.capture),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // item holding register
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff <= req_item;
      end
   end

   // timer tick arithmetic: prescaler carry-out decrements the counter
   assign presc_mask = 7'((8'd1 << shift_ff) - 8'd1);
   assign presc_sum  = {2'b00, presc_ff & presc_mask} + {1'b0, item_ff.elapsed_cycles};
   assign tick_dec   = presc_sum >> shift_ff;
   assign tdr_span   = {tdr_ff == 8'd0, tdr_ff};
   assign tick_fire  = (tdr_span <= tick_dec);

   // timer control write: tie forced, psc self-clears, tir can only be cleared
   assign tcr_wr       = item_ff.write_data | TCR_TIE;
   assign tcr_after_wr = (tcr_ff & (tcr_wr & TCR_TIR)) | (tcr_wr & ~(TCR_TIR | TCR_PSC));

   // program control write: bit 0 also sets bit 1
   assign pcr_wr = item_ff.write_data | {item_ff.write_data[6:0], 1'b0};

   // bus read mux
   always_comb begin
      rd_data_in = OPEN_BUS;
      case (item_ff.address)
         ADDR_PORT_A: rd_data_in = (latch_ff[0] & ddr_ff[0]) | (pin_ff[0] & ~ddr_ff[0]);
         ADDR_PORT_B: rd_data_in = (latch_ff[1] & ddr_ff[1]) | (pin_ff[1] & ~ddr_ff[1]);
         ADDR_PORT_C: rd_data_in = PORT_C_FIXED | (latch_ff[2] & ddr_ff[2])
                                   | (pin_ff[2] & ~ddr_ff[2]);
         ADDR_TDR:    rd_data_in = tdr_ff;
         ADDR_TCR:    rd_data_in = tcr_ff;
         ADDR_PCR:    rd_data_in = pcr_ff;
         default: begin
            if (ram_hit) begin
               rd_data_in = ram_rd_data;
            end
         end
      endcase
      if (item_ff.operation != OP_READ) begin
         rd_data_in = 8'h00;
      end
   end

   // state update for the held item
   always_comb begin
      latch_in = latch_ff;
      ddr_in   = ddr_ff;
      pin_in   = pin_ff;
      pcr_in   = pcr_ff;
      presc_in = presc_ff;
      tdr_in   = tdr_ff;
      tcr_in   = tcr_ff;
      irq_in   = irq_ff;
      case (item_ff.operation)
         OP_WRITE: begin
            case (item_ff.address)
               ADDR_PORT_A: latch_in[0] = item_ff.write_data;
               ADDR_PORT_B: latch_in[1] = item_ff.write_data;
               ADDR_PORT_C: latch_in[2] = item_ff.write_data & ~PORT_C_FIXED;
               ADDR_DDR_A:  ddr_in[0]   = item_ff.write_data;
               ADDR_DDR_B:  ddr_in[1]   = item_ff.write_data;
               ADDR_DDR_C:  ddr_in[2]   = item_ff.write_data & ~PORT_C_FIXED;
               ADDR_TDR:    tdr_in      = item_ff.write_data;
               ADDR_TCR: begin
                  tcr_in = tcr_after_wr;
                  irq_in = tcr_after_wr[7] && !tcr_after_wr[6];
                  if ((tcr_wr & TCR_PSC) != 8'h00) begin
                     presc_in = 7'd0;
                  end
               end
               ADDR_PCR:    pcr_in = (pcr_ff & PCR_KEEP) | (pcr_wr & PCR_WMASK);
               default: begin
               end
            endcase
         end
         OP_TICK: begin
            if (!ext_clk_ff) begin
               presc_in = presc_sum[6:0];
               tdr_in   = tdr_ff - tick_dec[7:0];
               if (tick_fire) begin
                  tcr_in = tcr_ff | TCR_TIR;
                  if ((tcr_ff & TCR_TIM) == 8'h00) begin
                     irq_in = 1'b1;
                  end
               end
            end
         end
         OP_PINS: begin
            case (item_ff.port_select)
               PORT_SEL_A: pin_in[0] = item_ff.write_data;
               PORT_SEL_B: pin_in[1] = item_ff.write_data;
               PORT_SEL_C: pin_in[2] = item_ff.write_data;
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   // architectural registers, changed only on commit
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            latch_ff[i] <= LATCH_RESET;
            ddr_ff[i]   <= DDR_RESET;
            pin_ff[i]   <= PIN_RESET;
         end
         pcr_ff   <= PCR_RESET;
         presc_ff <= PRESC_RESET;
         tdr_ff   <= TDR_RESET;
         tcr_ff   <= TCR_RESET;
         irq_ff   <= 1'b0;
      end else if (cmd.commit) begin
         latch_ff <= latch_in;
         ddr_ff   <= ddr_in;
         pin_ff   <= pin_in;
         pcr_ff   <= pcr_in;
         presc_ff <= presc_in;
         tdr_ff   <= tdr_in;
         tcr_ff   <= tcr_in;
         irq_ff   <= irq_in;
      end
   end

   // read data register
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rd_data_ff <= rd_data_in;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff   <= SHIFT_RESET;
         ext_clk_ff <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_PRESCALE: shift_ff   <= csr_data[2:0];
            CSR_EXT_CLK:  ext_clk_ff <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   // pin levels follow the committed latch and direction state
   assign read_data   = rd_data_ff;
   assign timer_irq   = irq_ff;
   assign port_a_pins = latch_ff[0] | ~ddr_ff[0];
   assign port_b_pins = (latch_ff[1] & ddr_ff[1]) | ~ddr_ff[1];
   assign port_c_pins = (latch_ff[2] & ddr_ff[2]) | ~ddr_ff[2];

   // the interrupt line is never up without the request bit
   a_irq_needs_tir: assert property (@(posedge clock) disable iff (reset)
      irq_ff |-> tcr_ff[7])
      else $error("timer irq without request bit");

endmodule

`default_nettype wire

FILE: rtl/mcu_timer_and_port_registers.sv
// Page-zero timer and I/O port block.
// Channels: req (slave side) carries one bus read, bus write, timer tick or pin
// update per beat; rsp (master side) returns exactly one beat per request with
// the read byte, the timer interrupt level and the three port pin levels as
// they stand after the request. csr is a write-only channel for the prescaler
// shift (index 0) and the external clock select (index 1), always ready, to be
// written while no request is outstanding.
// Timing: a request beat is taken in the idle state and executed in the execute
// state once the output register is free, so the block does not take a new
// item before the last one is committed; the two-state sequencer and the
// registered scratch ram read set this order. A request is accepted while an
// earlier response still waits in the output register; it then waits in
// execution until that response is taken, and req_tready stays low meanwhile.
// Reset (synchronous, active high): latches all ones, directions input, pins
// high, timer control 0x7F, counter 0xFF, prescaler 0x7F, no response pending.
// Scratch ram is not cleared and a byte must be written before it is read.
// depends on mcutp_pkg, mcutp_ctrl, mcutp_datapath
`default_nettype none

module mcu_timer_and_port_registers #(
   parameter int RAM_BYTES = mcutp_pkg::RAM_BYTES_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   // address [6:0], write_data [14:7], elapsed_cycles [22:15], zero fill
   input  wire logic [23:0] req_tdata,
   // operation [1:0], port_select [3:2]
   input  wire logic [3:0]  req_tuser,
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   // read_data [7:0], timer_irq [8], port_a_pins [16:9], port_b_pins [24:17],
   // port_c_pins [32:25], zero fill
   output      logic [39:0] rsp_tdata,
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic        csr_index,
   input  wire logic [7:0]  csr_data
);
   import mcutp_pkg::*;

   cmd_type    cmd;
   item_type   req_item;
   logic [7:0] read_data;
   logic       timer_irq;
   logic [7:0] port_a_pins;
   logic [7:0] port_b_pins;
   logic [7:0] port_c_pins;

   // unpack the request beat
   assign req_item.operation      = op_type'(req_tuser[1:0]);
   assign req_item.port_select    = req_tuser[3:2];
   assign req_item.address        = req_tdata[6:0];
   assign req_item.write_data     = req_tdata[14:7];
   assign req_item.elapsed_cycles = req_tdata[22:15];

   assign csr_ready = 1'b1;

   mcutp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   mcutp_datapath #(
      .RAM_BYTES (RAM_BYTES)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_item    (req_item),
      .csr_write   (csr_valid && csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .read_data   (read_data),
      .timer_irq   (timer_irq),
      .port_a_pins (port_a_pins),
      .port_b_pins (port_b_pins),
      .port_c_pins (port_c_pins)
   );

   // pack the response beat
   assign rsp_tdata = {7'd0, port_c_pins, port_b_pins, port_a_pins, timer_irq, read_data};

endmodule

`default_nettype wire
